/* rtl/mpls_label_stack_editor_assert.svh */
// assertion macros for the label stack editor's result serialiser
`ifndef MPLS_LABEL_STACK_EDITOR_ASSERT_SVH
`define MPLS_LABEL_STACK_EDITOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property checked while out of reset
`define MLSE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define MLSE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MLSE_ASSERT(lbl, clk, rst_n, prop, msg)

`define MLSE_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* rtl/mlse_pkg.sv */
package mlse_pkg;

    // sizes of the header and of the working stack
    localparam int MAX_OPS        = 3;
    localparam int STACK_WORDS    = 3;
    localparam int NUM_WORD_PORTS = 3;
    localparam int NUM_OP_PORTS   = 3;
    localparam int CAP            = STACK_WORDS + MAX_OPS;
    localparam int CNT_W          = $clog2(CAP + 1);
    localparam int IDX_W          = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int NOPS_W         = $clog2(MAX_OPS + 1);
    localparam int OP_W           = 22;
    localparam int WORD_W         = 32;
    localparam int LABEL_W        = 20;
    localparam int TTL_W          = 8;
    localparam logic [TTL_W-1:0] DEFAULT_TTL = 8'd255;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSUP   = 2'd1,
        ST_EXPIRED = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_SWAP    = 2'd1,
        OP_POP     = 2'd2,
        OP_UNKNOWN = 2'd3
    } t_op_kind;

    // header state as it travels down the pipeline; stk[0] is the top
    typedef struct packed {
        t_status                        status;
        logic                           empty;
        logic [CNT_W-1:0]               cnt;
        logic [1:0]                     depth;
        logic [TTL_W-1:0]               ttl;
        logic [NOPS_W-1:0]              nops;
        logic [MAX_OPS-1:0][OP_W-1:0]   ops;
        logic [CAP-1:0][WORD_W-1:0]     stk;
    } t_hdr;

endpackage

/* rtl/mlse_op_stage.sv */
module mlse_op_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  mlse_pkg::t_hdr i_hdr,
    output logic          o_valid,
    input  logic          i_ready,
    output mlse_pkg::t_hdr o_hdr
);
    import mlse_pkg::*;

    logic                r_v;
    t_hdr                r_hdr;
    t_hdr                n_hdr;
    t_op_kind            kind;
    logic [LABEL_W-1:0]  label;
    logic [TTL_W-1:0]    top_ttl;
    logic                apply;

    assign kind    = t_op_kind'(i_hdr.ops[0][OP_W-1:OP_W-2]);
    assign label   = i_hdr.ops[0][LABEL_W-1:0];
    assign top_ttl = i_hdr.stk[0][TTL_W-1:0];
    assign apply   = (i_hdr.nops != '0) && (i_hdr.status == ST_OK);

    // apply the head operation of the list to the working stack
    always_comb begin
        n_hdr = i_hdr;
        if (apply) begin
            for (int j = 0; j < MAX_OPS - 1; j++) begin
                n_hdr.ops[j] = i_hdr.ops[j+1];
            end
            n_hdr.ops[MAX_OPS-1] = '0;
            n_hdr.nops = i_hdr.nops - NOPS_W'(1);
            case (kind)
                OP_PUSH: begin
                    if (i_hdr.cnt != CNT_W'(CAP)) begin
                        for (int j = 1; j < CAP; j++) begin
                            n_hdr.stk[j] = i_hdr.stk[j-1];
                        end
                        n_hdr.stk[0] = {label, 3'b000, i_hdr.empty, i_hdr.ttl};
                        n_hdr.cnt    = i_hdr.cnt + CNT_W'(1);
                    end
                    n_hdr.empty = 1'b0;
                end
                OP_SWAP: begin
                    if (i_hdr.empty) begin
                        n_hdr.status = ST_NOSUP;
                    end else if (i_hdr.cnt == '0) begin
                        n_hdr.status = ST_MISSING;
                    end else if (top_ttl <= TTL_W'(1)) begin
                        n_hdr.status = ST_EXPIRED;
                    end else begin
                        n_hdr.stk[0] = {label, i_hdr.stk[0][11:8], top_ttl - TTL_W'(1)};
                    end
                end
                OP_POP: begin
                    if (i_hdr.empty) begin
                        n_hdr.status = ST_NOSUP;
                    end else if (i_hdr.cnt == '0) begin
                        n_hdr.status = ST_MISSING;
                    end else begin
                        n_hdr.empty = i_hdr.stk[0][8];
                        for (int j = 0; j < CAP - 1; j++) begin
                            n_hdr.stk[j] = i_hdr.stk[j+1];
                        end
                        n_hdr.stk[CAP-1] = '0;
                        n_hdr.cnt = i_hdr.cnt - CNT_W'(1);
                    end
                end
                default: begin
                    n_hdr.status = ST_NOSUP;
                end
            endcase
        end
    end

    // stage register, moves on when the next stage is free
    assign o_ready = !r_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_hdr <= n_hdr;
        end
    end

    assign o_valid = r_v;
    assign o_hdr   = r_hdr;

endmodule

/* rtl/mlse_out_ser.sv */
`include "mpls_label_stack_editor_assert.svh"

module mlse_out_ser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  mlse_pkg::t_hdr i_hdr,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [1:0]    o_status,
    output logic [1:0]    o_words_removed,
    output logic          o_word_valid,
    output logic [31:0]   o_out_word,
    output logic          o_last
);
    import mlse_pkg::*;

    logic              r_v;
    t_hdr              r_hdr;
    logic [IDX_W-1:0]  r_idx;
    logic [CNT_W-1:0]  nres;
    logic [CNT_W-1:0]  idx_ext;
    logic              fail;
    logic              has_words;
    logic              last;

    // number of results of the held header
    assign fail      = (r_hdr.status != ST_OK);
    assign has_words = !fail && (r_hdr.cnt != '0);
    assign nres      = has_words ? r_hdr.cnt : CNT_W'(1);
    assign idx_ext   = CNT_W'(r_idx);
    assign last      = (idx_ext + CNT_W'(1)) == nres;

    // take a new header once the final result has gone
    assign o_ready = !r_v || (i_ready && last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= 1'b0;
            r_idx <= '0;
        end else if (o_ready) begin
            r_v   <= i_valid;
            r_idx <= '0;
        end else if (i_ready) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_hdr <= i_hdr;
        end
    end

    // result fields from the held header
    assign o_valid         = r_v;
    assign o_status        = r_hdr.status;
    assign o_words_removed = fail ? 2'd0 : r_hdr.depth;
    assign o_word_valid    = has_words;
    assign o_out_word      = has_words ? r_hdr.stk[r_idx] : '0;
    assign o_last          = last;

    `MLSE_ASSERT(a_word_only_ok, i_clk, i_rst_n, (o_valid && o_word_valid) |-> (o_status == ST_OK), "stack word emitted with error status")
    `MLSE_ASSERT(a_error_single, i_clk, i_rst_n, (o_valid && o_status != ST_OK) |-> (o_last && !o_word_valid && r_idx == '0), "error transaction not a single final result")
    `MLSE_ASSERT(a_idx_in_range, i_clk, i_rst_n, r_v |-> (idx_ext < nres), "result index beyond edited stack")
    `MLSE_ASSERT(a_hold_on_stall, i_clk, i_rst_n, (r_v && !i_ready) |=> (r_v && $stable(r_idx)), "result index moved while stalled")

endmodule

/* rtl/mpls_label_stack_editor.sv */
// channel  | valid    | ready    | payload
// ---------+----------+----------+------------------------------------------------
// header   | i_valid  | o_ready  | route flags, ip ttl, depth, label words, ops
// result   | o_valid  | i_ready  | status, words removed, word valid, word, last
//
// pipeline: input register, one register stage per label operation (three),
// then the result serialiser; the first result is valid once the header has
// passed the input register, the three op stage registers and the serialiser
// register; a header makes one result per edited stack word (at least one),
// and the serialiser takes the next header only as its last result is taken
// reset clears valid bits and the expiry count; stalls hold every stage,
// empty stages still fill while the output waits
module mpls_label_stack_editor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_route_is_mpls,
    input  logic        i_route_is_inet,
    input  logic [7:0]  i_ip_ttl,
    input  logic [1:0]  i_stack_depth,
    input  logic [31:0] i_label_word_0,
    input  logic [31:0] i_label_word_1,
    input  logic [31:0] i_label_word_2,
    input  logic [21:0] i_label_op_0,
    input  logic [21:0] i_label_op_1,
    input  logic [21:0] i_label_op_2,
    input  logic [1:0]  i_op_count,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [1:0]  o_words_removed,
    output logic        o_word_valid,
    output logic [31:0] o_out_word,
    output logic        o_last
);
    import mlse_pkg::*;

    logic [NUM_WORD_PORTS-1:0][WORD_W-1:0] in_words;
    logic [NUM_OP_PORTS-1:0][OP_W-1:0]     in_ops;
    logic [1:0]                            depth;
    t_hdr                                  n_hdr;
    t_hdr                                  r_hdr;
    logic                                  r_v;
    logic [31:0]                           r_ttl_expired_count;

    logic [MAX_OPS:0] st_valid;
    logic [MAX_OPS:0] st_ready;
    t_hdr             st_hdr [MAX_OPS+1];

    assign in_words = {i_label_word_2, i_label_word_1, i_label_word_0};
    assign in_ops   = {i_label_op_2, i_label_op_1, i_label_op_0};

    // supplied word count, capped
    always_comb begin
        if (!i_route_is_mpls) begin
            depth = 2'd0;
        end else if (int'(i_stack_depth) > STACK_WORDS) begin
            depth = 2'(STACK_WORDS);
        end else begin
            depth = i_stack_depth;
        end
    end

    // unpack the header into the working stack, top first
    always_comb begin
        n_hdr        = '0;
        n_hdr.status = ST_OK;
        n_hdr.empty  = !i_route_is_mpls;
        n_hdr.cnt    = CNT_W'(depth);
        n_hdr.depth  = depth;
        n_hdr.ttl    = (!i_route_is_mpls && i_route_is_inet) ? i_ip_ttl : DEFAULT_TTL;
        n_hdr.nops   = (int'(i_op_count) > MAX_OPS) ? NOPS_W'(MAX_OPS) : NOPS_W'(i_op_count);
        for (int j = 0; j < MAX_OPS; j++) begin
            if (j < NUM_OP_PORTS) begin
                n_hdr.ops[j] = in_ops[j];
            end
        end
        for (int j = 0; j < CAP; j++) begin
            if (j < NUM_WORD_PORTS && j < int'(depth)) begin
                n_hdr.stk[j] = in_words[j];
            end
        end
    end

    // input register
    assign o_ready = !r_v || st_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_hdr <= n_hdr;
        end
    end

    assign st_valid[0] = r_v;
    assign st_hdr[0]   = r_hdr;

    // one stage per label operation
    for (genvar g = 0; g < MAX_OPS; g++) begin : g_op
        mlse_op_stage u_op (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (st_valid[g]),
            .o_ready (st_ready[g]),
            .i_hdr   (st_hdr[g]),
            .o_valid (st_valid[g+1]),
            .i_ready (st_ready[g+1]),
            .o_hdr   (st_hdr[g+1])
        );
    end

    // result serialiser
    mlse_out_ser u_ser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (st_valid[MAX_OPS]),
        .o_ready         (st_ready[MAX_OPS]),
        .i_hdr           (st_hdr[MAX_OPS]),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_words_removed (o_words_removed),
        .o_word_valid    (o_word_valid),
        .o_out_word      (o_out_word),
        .o_last          (o_last)
    );

    // expiry count, bumped as an expired header enters the serialiser
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl_expired_count <= '0;
        end else if (st_valid[MAX_OPS] && st_ready[MAX_OPS]
                     && st_hdr[MAX_OPS].status == ST_EXPIRED) begin
            r_ttl_expired_count <= r_ttl_expired_count + 32'd1;
        end
    end

endmodule

/* verif/tb_mpls_label_stack_editor.sv */
`timescale 1ns / 100ps

module tb_mpls_label_stack_editor;
    import mlse_pkg::*;

    localparam int RANDOM_HEADERS = 280;
    localparam int DRAIN_CYCLES   = 20;
    localparam int HOLD_START     = 600;
    localparam int HOLD_CYCLES    = 300;

    // one packet header as offered on the input channel
    typedef struct packed {
        logic             route_is_mpls;
        logic             route_is_inet;
        logic [7:0]       ip_ttl;
        logic [1:0]       stack_depth;
        logic [2:0][31:0] words;
        logic [2:0][21:0] ops;
        logic [1:0]       op_count;
    } label_hdr_t;

    // one result transaction
    typedef struct packed {
        t_status     status;
        logic [1:0]  words_removed;
        logic        word_valid;
        logic [31:0] out_word;
        logic        last;
    } edit_res_t;

    typedef struct {
        label_hdr_t hdr;
        logic       typed;
        edit_res_t  want;
    } stim_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_route_is_mpls;
    logic        i_route_is_inet;
    logic [7:0]  i_ip_ttl;
    logic [1:0]  i_stack_depth;
    logic [31:0] i_label_word_0;
    logic [31:0] i_label_word_1;
    logic [31:0] i_label_word_2;
    logic [21:0] i_label_op_0;
    logic [21:0] i_label_op_1;
    logic [21:0] i_label_op_2;
    logic [1:0]  i_op_count;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_status;
    logic [1:0]  o_words_removed;
    logic        o_word_valid;
    logic [31:0] o_out_word;
    logic        o_last;

    edit_res_t   pending_results[$];
    edit_res_t   pred_out[CAP];
    int          pred_n;
    logic [31:0] expiry_count;
    int          errors = 0;
    stim_row_t   directed_rows[$];
    edit_res_t   got_res;

    mpls_label_stack_editor dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_route_is_mpls (i_route_is_mpls),
        .i_route_is_inet (i_route_is_inet),
        .i_ip_ttl        (i_ip_ttl),
        .i_stack_depth   (i_stack_depth),
        .i_label_word_0  (i_label_word_0),
        .i_label_word_1  (i_label_word_1),
        .i_label_word_2  (i_label_word_2),
        .i_label_op_0    (i_label_op_0),
        .i_label_op_1    (i_label_op_1),
        .i_label_op_2    (i_label_op_2),
        .i_op_count      (i_op_count),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_words_removed (o_words_removed),
        .o_word_valid    (o_word_valid),
        .o_out_word      (o_out_word),
        .o_last          (o_last)
    );

    always #5 i_clk = ~i_clk;

    // apply the label operations of one header, results into pred_out
    function automatic void edit_label_stack(input label_hdr_t h);
        logic [31:0] stk[CAP];
        int          cnt;
        int          depth;
        int          nops;
        int          i;
        logic        empty;
        logic [7:0]  ttl;
        t_status     st;
        t_op_kind    kind;
        logic [19:0] lbl;
        logic [31:0] w;
        cnt   = 0;
        depth = 0;
        st    = ST_OK;
        ttl   = DEFAULT_TTL;
        empty = !h.route_is_mpls;
        if (!empty) begin
            depth = int'(h.stack_depth);
            if (depth > STACK_WORDS) depth = STACK_WORDS;
        end else if (h.route_is_inet) begin
            ttl = h.ip_ttl;
        end
        // bottom word goes in first, top ends at cnt-1
        for (i = depth - 1; i >= 0; i--) begin
            stk[cnt] = h.words[i];
            cnt++;
        end
        nops = int'(h.op_count);
        if (nops > MAX_OPS) nops = MAX_OPS;
        for (i = 0; i < nops && st == ST_OK; i++) begin
            kind = t_op_kind'(h.ops[i][21:20]);
            lbl  = h.ops[i][19:0];
            case (kind)
                OP_PUSH: begin
                    if (cnt < CAP) begin
                        stk[cnt] = {lbl, 3'b000, empty, ttl};
                        cnt++;
                    end
                    empty = 1'b0;
                end
                OP_SWAP: begin
                    if (empty) st = ST_NOSUP;
                    else if (cnt == 0) st = ST_MISSING;
                    else begin
                        w = stk[cnt-1];
                        // ttl of one or zero expires, zero included
                        if (w[7:0] <= 8'd1) begin
                            expiry_count = expiry_count + 32'd1;
                            st = ST_EXPIRED;
                        end else begin
                            stk[cnt-1] = {lbl, w[11:8], w[7:0] - 8'd1};
                        end
                    end
                end
                OP_POP: begin
                    if (empty) st = ST_NOSUP;
                    else if (cnt == 0) st = ST_MISSING;
                    else begin
                        empty = stk[cnt-1][8];
                        cnt--;
                    end
                end
                default: st = ST_NOSUP;
            endcase
        end
        // failure or empty stack gives a single result
        if (st != ST_OK) begin
            pred_out[0] = '{st, 2'd0, 1'b0, 32'd0, 1'b1};
            pred_n = 1;
        end else if (cnt == 0) begin
            pred_out[0] = '{ST_OK, 2'(depth), 1'b0, 32'd0, 1'b1};
            pred_n = 1;
        end else begin
            for (i = 0; i < cnt; i++)
                pred_out[i] = '{ST_OK, 2'(depth), 1'b1, stk[cnt-1-i], i == cnt - 1};
            pred_n = cnt;
        end
    endfunction

    function automatic logic [31:0] lw(input logic [19:0] lbl, input logic [2:0] exp,
                                       input logic s, input logic [7:0] ttl);
        return {lbl, exp, s, ttl};
    endfunction

    function automatic logic [21:0] op_word(input t_op_kind k, input logic [19:0] lbl);
        return {k, lbl};
    endfunction

    function automatic label_hdr_t mk(input logic m, input logic inet,
                                      input logic [7:0] ttl, input logic [1:0] d,
                                      input logic [31:0] w0, input logic [31:0] w1,
                                      input logic [31:0] w2, input logic [21:0] o0,
                                      input logic [21:0] o1, input logic [21:0] o2,
                                      input logic [1:0] n);
        label_hdr_t h;
        h.route_is_mpls = m;
        h.route_is_inet = inet;
        h.ip_ttl        = ttl;
        h.stack_depth   = d;
        h.words         = {w2, w1, w0};
        h.ops           = {o2, o1, o0};
        h.op_count      = n;
        return h;
    endfunction

    function automatic stim_row_t by_model(input label_hdr_t h);
        stim_row_t r;
        r.hdr   = h;
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic stim_row_t typed_row(input label_hdr_t h, input t_status st,
                                            input logic [1:0] rem, input logic wv,
                                            input logic [31:0] word, input logic last);
        stim_row_t r;
        r.hdr   = h;
        r.typed = 1'b1;
        r.want  = '{st, rem, wv, word, last};
        return r;
    endfunction

    // ttl values biased towards the expiry edges
    function automatic logic [7:0] pick_ttl();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd2;
            3:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // mostly well-formed stacks and op lists, some pure noise
    function automatic label_hdr_t rand_hdr();
        label_hdr_t  h;
        logic [31:0] w;
        int          k;
        int          r;
        t_op_kind    kind;
        if ($urandom_range(0, 6) == 0) begin
            h = label_hdr_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
            return h;
        end
        h.route_is_mpls = ($urandom_range(0, 3) != 0);
        h.route_is_inet = 1'($urandom);
        h.ip_ttl        = pick_ttl();
        h.stack_depth   = 2'($urandom);
        for (k = 0; k < 3; k++) begin
            w = $urandom;
            // bottom supplied word usually carries the S bit
            if (k == int'(h.stack_depth) - 1) w[8] = ($urandom_range(0, 3) != 0);
            else w[8] = ($urandom_range(0, 7) == 0);
            w[7:0] = pick_ttl();
            h.words[k] = w;
        end
        for (k = 0; k < 3; k++) begin
            r = $urandom_range(0, 19);
            if (r < 7) kind = OP_PUSH;
            else if (r < 13) kind = OP_SWAP;
            else if (r < 19) kind = OP_POP;
            else kind = OP_UNKNOWN;
            h.ops[k] = op_word(kind, 20'($urandom));
        end
        h.op_count = ($urandom_range(0, 6) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
        return h;
    endfunction

    // offer one header and hold it until the transaction is taken
    task automatic send_header(input stim_row_t row);
        int k;
        @(negedge i_clk);
        i_valid         <= 1'b1;
        i_route_is_mpls <= row.hdr.route_is_mpls;
        i_route_is_inet <= row.hdr.route_is_inet;
        i_ip_ttl        <= row.hdr.ip_ttl;
        i_stack_depth   <= row.hdr.stack_depth;
        i_label_word_0  <= row.hdr.words[0];
        i_label_word_1  <= row.hdr.words[1];
        i_label_word_2  <= row.hdr.words[2];
        i_label_op_0    <= row.hdr.ops[0];
        i_label_op_1    <= row.hdr.ops[1];
        i_label_op_2    <= row.hdr.ops[2];
        i_op_count      <= row.hdr.op_count;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        edit_label_stack(row.hdr);
        if (row.typed) pending_results.push_back(row.want);
        else for (k = 0; k < pred_n; k++) pending_results.push_back(pred_out[k]);
    endtask

    task automatic pause(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    // result side: compare each transaction with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: status %0d word 0x%0h",
                       o_status, o_out_word);
                errors++;
            end else begin
                got_res = pending_results.pop_front();
                check_field("status", 32'(got_res.status), 32'(o_status));
                check_field("words_removed", 32'(got_res.words_removed),
                            32'(o_words_removed));
                check_field("word_valid", 32'(got_res.word_valid), 32'(o_word_valid));
                check_field("out_word", got_res.out_word, o_out_word);
                check_field("last", 32'(got_res.last), 32'(o_last));
            end
        end
    end

    // receiver stalls: patterns picked at random, one long hold-off
    initial begin
        int         cyc;
        int         mode;
        logic [7:0] mask;
        cyc     = 0;
        mode    = 0;
        mask    = 8'hff;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc % 64 == 0) begin
                mode = $urandom_range(0, 3);
                mask = 8'($urandom);
            end
            if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES) i_ready <= 1'b0;
            else begin
                case (mode)
                    0:       i_ready <= 1'b1;
                    1:       i_ready <= 1'($urandom);
                    2:       i_ready <= ($urandom_range(0, 3) == 0);
                    default: i_ready <= mask[cyc % 8];
                endcase
            end
        end
    end

    // stimulus
    initial begin
        int n;
        int burst;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_route_is_mpls = 1'b0;
        i_route_is_inet = 1'b0;
        i_ip_ttl        = 8'd0;
        i_stack_depth   = 2'd0;
        i_label_word_0  = 32'd0;
        i_label_word_1  = 32'd0;
        i_label_word_2  = 32'd0;
        i_label_op_0    = 22'd0;
        i_label_op_1    = 22'd0;
        i_label_op_2    = 22'd0;
        i_op_count      = 2'd0;
        expiry_count    = 32'd0;

        // directed headers
        directed_rows.push_back(typed_row(mk(0, 0, 8'd0, 2'd0, '0, '0, '0, '0, '0, '0, 2'd0),
                                          ST_OK, 2'd0, 1'b0, 32'd0, 1'b1));
        directed_rows.push_back(by_model(mk(0, 1, 8'd64, 2'd0, '0, '0, '0,
                                            op_word(OP_PUSH, 20'hABCDE), '0, '0, 2'd1)));
        directed_rows.push_back(typed_row(mk(0, 1, 8'd9, 2'd0, '0, '0, '0,
                                             op_word(OP_SWAP, 20'h1), '0, '0, 2'd1),
                                          ST_NOSUP, 2'd0, 1'b0, 32'd0, 1'b1));
        directed_rows.push_back(typed_row(mk(0, 0, 8'd9, 2'd0, '0, '0, '0,
                                             op_word(OP_POP, 20'h0), '0, '0, 2'd1),
                                          ST_NOSUP, 2'd0, 1'b0, 32'd0, 1'b1));
        directed_rows.push_back(typed_row(mk(1, 0, 8'd0, 2'd1, lw(20'h5, 3'd0, 1, 8'd9), '0, '0,
                                             op_word(OP_UNKNOWN, 20'hFFFFF), '0, '0, 2'd1),
                                          ST_NOSUP, 2'd0, 1'b0, 32'd0, 1'b1));
        directed_rows.push_back(typed_row(mk(1, 0, 8'd0, 2'd0, '0, '0, '0,
                                             op_word(OP_SWAP, 20'h7), '0, '0, 2'd1),
                                          ST_MISSING, 2'd0, 1'b0, 32'd0, 1'b1));
        directed_rows.push_back(typed_row(mk(1, 0, 8'd0, 2'd0, '0, '0, '0,
                                             op_word(OP_POP, 20'h7), '0, '0, 2'd1),
                                          ST_MISSING, 2'd0, 1'b0, 32'd0, 1'b1));
        directed_rows.push_back(typed_row(mk(1, 0, 8'd0, 2'd1, lw(20'h9, 3'd5, 1, 8'd1), '0, '0,
                                             op_word(OP_SWAP, 20'h3), '0, '0, 2'd1),
                                          ST_EXPIRED, 2'd0, 1'b0, 32'd0, 1'b1));
        // ttl of zero must not wrap to 255
        directed_rows.push_back(typed_row(mk(1, 0, 8'd0, 2'd1, lw(20'h9, 3'd5, 1, 8'd0), '0, '0,
                                             op_word(OP_SWAP, 20'h3), '0, '0, 2'd1),
                                          ST_EXPIRED, 2'd0, 1'b0, 32'd0, 1'b1));
        directed_rows.push_back(by_model(mk(1, 0, 8'd0, 2'd1, lw(20'h9, 3'd7, 1, 8'd2), '0, '0,
                                            op_word(OP_SWAP, 20'hFFFFF), '0, '0, 2'd1)));
        directed_rows.push_back(by_model(mk(1, 1, 8'd255, 2'd3, '1, '1, '1,
                                            op_word(OP_SWAP, 20'h0), op_word(OP_POP, 20'h0),
                                            op_word(OP_SWAP, 20'hFFFFF), 2'd3)));
        // popping through the bottom of stack leaves nothing
        directed_rows.push_back(typed_row(mk(1, 0, 8'd0, 2'd3, lw(20'h1, 3'd0, 0, 8'd9),
                                             lw(20'h2, 3'd0, 0, 8'd9), lw(20'h3, 3'd0, 1, 8'd9),
                                             op_word(OP_POP, 20'h0), op_word(OP_POP, 20'h0),
                                             op_word(OP_POP, 20'h0), 2'd3),
                                          ST_OK, 2'd3, 1'b0, 32'd0, 1'b1));
        directed_rows.push_back(typed_row(mk(1, 0, 8'd0, 2'd3, lw(20'h1, 3'd0, 0, 8'd9),
                                             lw(20'h2, 3'd0, 0, 8'd9), lw(20'h3, 3'd0, 0, 8'd9),
                                             op_word(OP_POP, 20'h0), op_word(OP_POP, 20'h0),
                                             op_word(OP_POP, 20'h0), 2'd3),
                                          ST_OK, 2'd3, 1'b0, 32'd0, 1'b1));
        // supplied words used up while the stack is not empty
        directed_rows.push_back(typed_row(mk(1, 0, 8'd0, 2'd2, lw(20'h1, 3'd0, 0, 8'd9),
                                             lw(20'h2, 3'd0, 0, 8'd9), '0,
                                             op_word(OP_POP, 20'h0), op_word(OP_POP, 20'h0),
                                             op_word(OP_SWAP, 20'h4), 2'd3),
                                          ST_MISSING, 2'd0, 1'b0, 32'd0, 1'b1));
        directed_rows.push_back(by_model(mk(1, 1, 8'd7, 2'd1, lw(20'h44, 3'd2, 1, 8'd30), '0, '0,
                                            op_word(OP_POP, 20'h0), op_word(OP_PUSH, 20'h11),
                                            op_word(OP_PUSH, 20'h22), 2'd3)));
        directed_rows.push_back(by_model(mk(1, 0, 8'd0, 2'd3, lw(20'hA, 3'd1, 0, 8'd10),
                                            lw(20'hB, 3'd2, 0, 8'd20), lw(20'hC, 3'd3, 1, 8'd30),
                                            op_word(OP_PUSH, 20'h1), op_word(OP_PUSH, 20'h2),
                                            op_word(OP_PUSH, 20'hFFFFF), 2'd3)));
        directed_rows.push_back(by_model(mk(0, 1, 8'd0, 2'd0, '0, '0, '0,
                                            op_word(OP_PUSH, 20'h1), op_word(OP_PUSH, 20'h2),
                                            op_word(OP_PUSH, 20'h3), 2'd3)));
        directed_rows.push_back(by_model(mk(0, 0, 8'd200, 2'd0, '0, '0, '0,
                                            op_word(OP_PUSH, 20'h12345), '0, '0, 2'd1)));
        directed_rows.push_back(by_model(mk(1, 1, 8'd255, 2'd3, '1, '1, '1, '1, '1, '1, 2'd0)));
        directed_rows.push_back(by_model(mk(1, 0, 8'd0, 2'd2, lw(20'h8, 3'd4, 0, 8'd100),
                                            lw(20'h9, 3'd0, 1, 8'd50),  '0,
                                            op_word(OP_SWAP, 20'h77), '1, '1, 2'd1)));
        directed_rows.push_back(by_model(mk(0, 1, 8'd255, 2'd3, '1, '1, '1,
                                            '0, '1, '1, 2'd1)));
        directed_rows.push_back(typed_row(mk(1, 0, 8'd0, 2'd2, lw(20'h1, 3'd0, 0, 8'd9),
                                             lw(20'h2, 3'd0, 1, 8'd1), '0,
                                             op_word(OP_POP, 20'h0), op_word(OP_SWAP, 20'h5),
                                             '0, 2'd2),
                                          ST_EXPIRED, 2'd0, 1'b0, 32'd0, 1'b1));
        directed_rows.push_back(by_model(mk(1, 0, 8'd0, 2'd3, '0, '0, '0,
                                            op_word(OP_POP, 20'h0), op_word(OP_PUSH, 20'hFFFFF),
                                            op_word(OP_SWAP, 20'h0), 2'd3)));
        directed_rows.push_back(typed_row(mk(1, 0, 8'd0, 2'd1, lw(20'h3, 3'd0, 1, 8'd255), '0, '0,
                                             op_word(OP_SWAP, 20'h6), op_word(OP_UNKNOWN, 20'h0),
                                             op_word(OP_PUSH, 20'h1), 2'd3),
                                          ST_NOSUP, 2'd0, 1'b0, 32'd0, 1'b1));

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            send_header(directed_rows[r]);
            if ($urandom_range(0, 2) == 0) pause($urandom_range(1, 3));
        end

        // random headers in bursts with gaps between them
        burst = $urandom_range(1, 16);
        for (n = 0; n < RANDOM_HEADERS; n++) begin
            send_header(by_model(rand_hdr()));
            burst--;
            if (burst == 0) begin
                if ($urandom_range(0, 4) == 0) pause($urandom_range(10, 30));
                else pause($urandom_range(0, 6));
                burst = $urandom_range(1, 16);
            end
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("tb_mpls_label_stack_editor: done, clean");
        else
            $display("tb_mpls_label_stack_editor: done, errors");
        $finish;
    end

    // watchdog
    initial begin
        #1000000;
        $display("tb_mpls_label_stack_editor: done, errors");
        $finish;
    end

endmodule

/* mpls_label_stack_editor.f */
+incdir+rtl
rtl/mlse_pkg.sv
rtl/mlse_op_stage.sv
rtl/mlse_out_ser.sv
rtl/mpls_label_stack_editor.sv
verif/tb_mpls_label_stack_editor.sv
